// File: rtl/zone_pollution_window_monitor_defines.svh
// Assertion macros shared by the RTL.
`ifndef ZONE_POLLUTION_WINDOW_MONITOR_DEFINES_SVH
`define ZONE_POLLUTION_WINDOW_MONITOR_DEFINES_SVH

`ifndef SYNTH
`define ZPWM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zpwm: implication check failed");
`define ZPWM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zpwm: next-cycle check failed");
`else
`define ZPWM_ASSERT_IMP(lbl, ante, cons)
`define ZPWM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/zpwm_pkg.sv
package zpwm_pkg;

	localparam int NUM_ZONES   = 5;
	localparam int WINDOW_DAYS = 3;
	localparam int POLLUTANTS  = 6;

	localparam int LEVEL_W = 16;
	localparam int ZONE_W  = 3;
	localparam int ROW_W   = POLLUTANTS * LEVEL_W;
	localparam int SUM_W   = LEVEL_W + ((WINDOW_DAYS > 1) ? $clog2(WINDOW_DAYS) : 0);
	localparam int FILL_W  = $clog2(WINDOW_DAYS + 1);
	localparam int SLOT_W  = (WINDOW_DAYS > 1) ? $clog2(WINDOW_DAYS) : 1;
	localparam int ZONE_AW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int LIM_W     = 16;

	// quality index: floor(acc / (60 n)) = floor((acc >> 2) / (15 n))
	localparam int ACC_W     = SUM_W + 8;
	localparam int QX_W      = ACC_W - 2;
	localparam int RECIP_W   = 25;
	localparam int QPROD_W   = QX_W + RECIP_W;
	localparam int Q_W       = 21;
	localparam logic [RECIP_W-1:0] DIV15_MUL = 25'd17895698;
	localparam int DIV15_SH  = 28;
	localparam logic [RECIP_W-1:0] DIV45_MUL = 25'd23860930;
	localparam int DIV45_SH  = 30;

	// average of three readings
	localparam int AVG_RECIP_W = 19;
	localparam logic [AVG_RECIP_W-1:0] DIV3_MUL = 19'd349526;
	localparam int AVG_SH      = 20;
	localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

	localparam logic [7:0] IDX_WEIGHT [POLLUTANTS] = '{8'd40, 8'd20, 8'd10, 8'd25, 8'd50, 8'd1};
	localparam logic [CFG_W-1:0] LIMIT_RESET [POLLUTANTS] = '{
		32'd20971920, 32'd41943840, 32'd94373440,
		32'd31457920, 32'd10486080, 32'd943734400
	};

	localparam int IN_TDATA_W  = ((ZONE_W + ROW_W + 7) / 8) * 8;
	localparam int IN_TUSER_W  = 1;

	localparam int OD_DAYS_LSB = 0;
	localparam int OD_LVL_LSB  = OD_DAYS_LSB + 2;
	localparam int OD_QI_LSB   = OD_LVL_LSB + ROW_W;
	localparam int OD_EXC_LSB  = OD_QI_LSB + LEVEL_W;
	localparam int OD_ANY      = OD_EXC_LSB + 2 * POLLUTANTS;
	localparam int OUT_TDATA_W = ((OD_ANY + 1 + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	typedef enum logic [0:0] {
		OP_RECORD  = 1'b0,
		OP_PREDICT = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_DATA  = 2'd1,
		ST_BAD_ZONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		EXC_NONE  = 2'd0,
		EXC_WHO   = 2'd1,
		EXC_LOCAL = 2'd2
	} exceed_t;

endpackage

// File: rtl/zpwm_ram.sv
module zpwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/zone_pollution_window_monitor.sv
// Channel   Dir  Transfer when                  Content
// s_axis    in   s_axis_tvalid & s_axis_tready   record / predict item
// m_axis    out  m_axis_tvalid & m_axis_tready   one result per item
// cfg       in   cfg_we                          limit register write
//
// Two register stages: window RAM read / input register, then result register.
// One item per cycle unless stalled: one row write or a registered read of the slot RAMs.
// An item passes stage one, then the result register, which holds it until m_axis_tready.
// Reset clears fill counts and ring pointers, loads default limits; RAMs are not cleared.
// A stalled result holds a full stage one and blocks input until the result transfers.
`include "zone_pollution_window_monitor_defines.svh"

module zone_pollution_window_monitor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// zone, pm25_level, pm10_level, ozone_level, no2_level, so2_level, co2_level
	input  logic [zpwm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// opcode
	input  logic [zpwm_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// days_used, pm25_out, pm10_out, ozone_out, no2_out, so2_out, co2_out,
	// quality_index, exceed_levels, any_exceed
	output logic [zpwm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// status
	output logic [zpwm_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
	input  logic                                  cfg_we,
	input  logic [zpwm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [zpwm_pkg::CFG_W-1:0]            cfg_data
);

	import zpwm_pkg::*;

	logic [CFG_W-1:0] limit_q [POLLUTANTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POLLUTANTS; i++) begin
				limit_q[i] <= LIMIT_RESET[i];
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(POLLUTANTS))) begin
			limit_q[cfg_index] <= cfg_data;
		end
	end

	// input decode
	logic                in_fire;
	opcode_t             in_op;
	logic [ZONE_W-1:0]   in_zone;
	logic [ROW_W-1:0]    in_row;
	logic                in_bad;
	logic [ZONE_AW-1:0]  zaddr;
	logic [FILL_W-1:0]   cur_fill;
	logic [SLOT_W-1:0]   cur_slot;
	logic [FILL_W-1:0]   fill_new;
	logic [SLOT_W-1:0]   slot_new;
	logic                rec_wr;
	logic                pred_rd;
	logic                s1_adv;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign in_op   = opcode_t'(s_axis_tuser[0]);
	assign in_zone = s_axis_tdata[ZONE_W-1:0];
	assign in_row  = s_axis_tdata[ZONE_W +: ROW_W];
	assign in_bad  = (32'(in_zone) >= 32'(NUM_ZONES));
	assign zaddr   = ZONE_AW'(in_zone);

	logic [FILL_W-1:0] fill_q [NUM_ZONES];
	logic [SLOT_W-1:0] slot_q [NUM_ZONES];

	assign cur_fill = in_bad ? '0 : fill_q[zaddr];
	assign cur_slot = in_bad ? '0 : slot_q[zaddr];
	assign fill_new = (cur_fill == FILL_W'(WINDOW_DAYS)) ? cur_fill : cur_fill + 1'b1;
	assign slot_new = (cur_slot == SLOT_W'(WINDOW_DAYS - 1)) ? '0 : cur_slot + 1'b1;
	assign rec_wr   = in_fire && !in_bad && (in_op == OP_RECORD);
	assign pred_rd  = in_fire && !in_bad && (in_op == OP_PREDICT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int z = 0; z < NUM_ZONES; z++) begin
				fill_q[z] <= '0;
				slot_q[z] <= '0;
			end
		end else if (rec_wr) begin
			fill_q[zaddr] <= fill_new;
			slot_q[zaddr] <= slot_new;
		end
	end

	// one RAM per ring slot, rows indexed by zone
	logic [ROW_W-1:0] rd_row [WINDOW_DAYS];

	for (genvar g = 0; g < WINDOW_DAYS; g++) begin : g_slot
		zpwm_ram #(
			.WIDTH(ROW_W),
			.DEPTH(NUM_ZONES)
		) u_ram (
			.clk  (clk),
			.we   (rec_wr && (cur_slot == SLOT_W'(g))),
			.waddr(zaddr),
			.wdata(in_row),
			.re   (pred_rd),
			.raddr(zaddr),
			.rdata(rd_row[g])
		);
	end

	// stage one
	logic              valid_s1;
	opcode_t           op_s1;
	status_t           status_s1;
	logic [FILL_W-1:0] days_s1;
	logic [ROW_W-1:0]  levels_s1;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;

	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= in_op;
			levels_s1 <= in_row;
			days_s1   <= (in_op == OP_RECORD) ? fill_new : cur_fill;
			if (in_bad) begin
				status_s1 <= ST_BAD_ZONE;
			end else if ((in_op == OP_PREDICT) && (cur_fill == '0)) begin
				status_s1 <= ST_NO_DATA;
			end else begin
				status_s1 <= ST_OK;
			end
		end
	end

	// result datapath
	logic [FILL_W-1:0]      n_eff;
	logic [SUM_W-1:0]       psum    [POLLUTANTS];
	logic [LEVEL_W-1:0]     avg     [POLLUTANTS];
	logic [AVG_PROD_W-1:0]  avg_prod[POLLUTANTS];
	exceed_t                code    [POLLUTANTS];
	logic [SUM_W-1:0]       lim_loc [POLLUTANTS];
	logic [SUM_W-1:0]       lim_who [POLLUTANTS];
	logic [ACC_W-1:0]       acc;
	logic                   div3;
	logic [QX_W-1:0]        qx;
	logic [RECIP_W-1:0]     qm;
	logic [QPROD_W-1:0]     qprod;
	logic [QPROD_W-1:0]     qshift;
	logic [Q_W-1:0]         qval;
	logic [LEVEL_W-1:0]     qidx;
	logic                   any_exc;
	logic [OUT_TDATA_W-1:0] out_next;

	assign n_eff = (op_s1 == OP_RECORD) ? FILL_W'(1) : days_s1;

	always_comb begin
		for (int p = 0; p < POLLUTANTS; p++) begin
			if (op_s1 == OP_RECORD) begin
				psum[p] = SUM_W'(levels_s1[p*LEVEL_W +: LEVEL_W]);
			end else begin
				psum[p] = '0;
				for (int g = 0; g < WINDOW_DAYS; g++) begin
					if (FILL_W'(g) < days_s1) begin
						psum[p] = psum[p] + SUM_W'(rd_row[g][p*LEVEL_W +: LEVEL_W]);
					end
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int p = 0; p < POLLUTANTS; p++) begin
			acc = acc + ACC_W'(psum[p]) * ACC_W'(IDX_WEIGHT[p]);
		end
	end

	// n is zero to three readings; it is zero only when the status is not OK
	always_comb begin
		div3 = (n_eff == FILL_W'(3));
		if (div3) begin
			qx = QX_W'(acc >> 2);
			qm = DIV45_MUL;
		end else if (n_eff == FILL_W'(2)) begin
			qx = QX_W'(acc >> 3);
			qm = DIV15_MUL;
		end else begin
			qx = QX_W'(acc >> 2);
			qm = DIV15_MUL;
		end
		qprod  = QPROD_W'(qx) * QPROD_W'(qm);
		qshift = div3 ? (qprod >> DIV45_SH) : (qprod >> DIV15_SH);
		qval   = qshift[Q_W-1:0];
		qidx   = (|qval[Q_W-1:LEVEL_W]) ? '1 : qval[LEVEL_W-1:0];
	end

	always_comb begin
		any_exc = 1'b0;
		for (int p = 0; p < POLLUTANTS; p++) begin
			avg_prod[p] = AVG_PROD_W'(psum[p]) * AVG_PROD_W'(DIV3_MUL);
			case (n_eff)
				FILL_W'(2): avg[p] = LEVEL_W'(psum[p] >> 1);
				FILL_W'(3): avg[p] = LEVEL_W'(avg_prod[p] >> AVG_SH);
				default:    avg[p] = psum[p][LEVEL_W-1:0];
			endcase
			case (n_eff)
				FILL_W'(2): begin
					lim_loc[p] = SUM_W'(limit_q[p][CFG_W-1:LIM_W]) << 1;
					lim_who[p] = SUM_W'(limit_q[p][LIM_W-1:0]) << 1;
				end
				FILL_W'(3): begin
					lim_loc[p] = SUM_W'(limit_q[p][CFG_W-1:LIM_W])
						+ (SUM_W'(limit_q[p][CFG_W-1:LIM_W]) << 1);
					lim_who[p] = SUM_W'(limit_q[p][LIM_W-1:0])
						+ (SUM_W'(limit_q[p][LIM_W-1:0]) << 1);
				end
				default: begin
					lim_loc[p] = SUM_W'(limit_q[p][CFG_W-1:LIM_W]);
					lim_who[p] = SUM_W'(limit_q[p][LIM_W-1:0]);
				end
			endcase
			if (psum[p] > lim_loc[p]) begin
				code[p] = EXC_LOCAL;
			end else if (psum[p] > lim_who[p]) begin
				code[p] = EXC_WHO;
			end else begin
				code[p] = EXC_NONE;
			end
			if (code[p] != EXC_NONE) begin
				any_exc = 1'b1;
			end
		end
	end

	always_comb begin
		out_next = '0;
		if (status_s1 == ST_OK) begin
			out_next[OD_DAYS_LSB +: FILL_W] = days_s1;
			out_next[OD_QI_LSB +: LEVEL_W]  = qidx;
			for (int p = 0; p < POLLUTANTS; p++) begin
				out_next[OD_LVL_LSB + p*LEVEL_W +: LEVEL_W] = avg[p];
				if (op_s1 == OP_PREDICT) begin
					out_next[OD_EXC_LSB + 2*p +: 2] = code[p];
				end
			end
			if (op_s1 == OP_PREDICT) begin
				out_next[OD_ANY] = any_exc;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_data_q <= out_next;
			out_user_q <= status_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	`ZPWM_ASSERT_IMP(a_bad_zone_clear, m_axis_tvalid && (m_axis_tuser == ST_BAD_ZONE), m_axis_tdata == '0)
	`ZPWM_ASSERT_IMP(a_ok_has_days, m_axis_tvalid && (m_axis_tuser == ST_OK), m_axis_tdata[OD_DAYS_LSB +: FILL_W] != '0)
	`ZPWM_ASSERT_IMP(a_stall_blocks_in, valid_s1 && m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`ZPWM_ASSERT_NXT(a_stall_holds_s1, valid_s1 && m_axis_tvalid && !m_axis_tready, valid_s1 && $stable(levels_s1))

endmodule
